[hw/rtl/lcpg_pkg.sv]
// Package for the LED chaser pattern generator: sizes, masks, mode and
// speed codes, register indexes and the pattern state struct.
// No dependencies.
`default_nettype none

package lcpg_pkg;

    // LEDs on each of the two rows (2 to 8)
    localparam int unsigned LEDS_PER_ROW = 5;

    // Mask over both rows in the pattern word, and the word just past it
    localparam logic [31:0] DBL_MASK  = (32'd1 << (2 * LEDS_PER_ROW)) - 32'd1;
    localparam logic [31:0] WRAP_WORD = 32'd1 << (2 * LEDS_PER_ROW);

    // Mask of one row and its top LED, in row register width
    localparam logic [7:0] ROW_MASK = 8'((16'd1 << LEDS_PER_ROW) - 16'd1);
    localparam logic [7:0] TOP_LED  = 8'(16'd1 << (LEDS_PER_ROW - 1));

    // Mode button bits, lowest set bit wins
    localparam logic [4:0] MODE_FILL     = 5'h01;
    localparam logic [4:0] MODE_FORWARD  = 5'h02;
    localparam logic [4:0] MODE_BACKWARD = 5'h04;
    localparam logic [4:0] MODE_KNIGHT   = 5'h08;
    localparam logic [4:0] MODE_MIRROR   = 5'h10;
    localparam logic [4:0] MODE_RESET    = MODE_FILL;

    // Speed button bits
    localparam logic [2:0] SPEED_UP    = 3'h1;
    localparam logic [2:0] SPEED_DOWN  = 3'h2;
    localparam logic [2:0] SPEED_RESET = 3'h4;

    // Configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PERIOD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD     = 4'd1;
    localparam logic [7:0] DEFAULT_PERIOD_RST = 8'd20;
    localparam logic [7:0] MAX_PERIOD_RST     = 8'd200;

    // Pattern state carried between ticks
    typedef struct packed {
        logic [31:0] pattern_word;
        logic [7:0]  row_one;
        logic [7:0]  row_two;
        logic        dir;
    } pat_state_t;

endpackage

`default_nettype wire

[hw/rtl/lcpg_pattern.sv]
// Next-step logic of the LED chaser: one pattern step of the active mode.
// Depends on lcpg_pkg.
`default_nettype none

module lcpg_pattern (
    input  wire logic [4:0]          mode_bits,
    input  wire lcpg_pkg::pat_state_t state_cur,
    output lcpg_pkg::pat_state_t      state_nxt
);

    logic [31:0] word_shl;
    logic [31:0] word_fill;
    logic [31:0] word_shr;
    logic [7:0]  r1_shl;
    logic [7:0]  r1_shr;
    logic [7:0]  r2_shl;
    logic [7:0]  r2_shr;

    assign word_shl  = {state_cur.pattern_word[30:0], 1'b0};
    assign word_fill = {state_cur.pattern_word[30:0], 1'b1};
    assign word_shr  = {1'b0, state_cur.pattern_word[31:1]};
    assign r1_shl    = {state_cur.row_one[6:0], 1'b0};
    assign r1_shr    = {1'b0, state_cur.row_one[7:1]};
    assign r2_shl    = {state_cur.row_two[6:0], 1'b0};
    assign r2_shr    = {1'b0, state_cur.row_two[7:1]};

    // Step the active mode; rows follow the word in the word-driven modes
    always_comb begin
        state_nxt = state_cur;
        priority if ((mode_bits & lcpg_pkg::MODE_FILL) != '0) begin
            if (state_cur.dir) begin
                if ((state_cur.pattern_word & lcpg_pkg::DBL_MASK) == '0) begin
                    state_nxt.pattern_word = 32'd1;
                end else begin
                    state_nxt.pattern_word = word_fill;
                    if (word_fill >= lcpg_pkg::DBL_MASK) begin
                        state_nxt.dir = 1'b0;
                    end
                end
            end else begin
                state_nxt.pattern_word = word_shl;
                if ((word_shl & lcpg_pkg::DBL_MASK) == '0) begin
                    state_nxt.dir = 1'b1;
                end
            end
            state_nxt.row_one = 8'(state_nxt.pattern_word) & lcpg_pkg::ROW_MASK;
            state_nxt.row_two = 8'(state_nxt.pattern_word >> lcpg_pkg::LEDS_PER_ROW)
                                & lcpg_pkg::ROW_MASK;
        end else if ((mode_bits & lcpg_pkg::MODE_FORWARD) != '0) begin
            if (word_shl > lcpg_pkg::DBL_MASK || word_shl == '0) begin
                state_nxt.pattern_word = 32'd1;
            end else begin
                state_nxt.pattern_word = word_shl;
            end
            state_nxt.row_one = 8'(state_nxt.pattern_word) & lcpg_pkg::ROW_MASK;
            state_nxt.row_two = 8'(state_nxt.pattern_word >> lcpg_pkg::LEDS_PER_ROW)
                                & lcpg_pkg::ROW_MASK;
        end else if ((mode_bits & lcpg_pkg::MODE_BACKWARD) != '0) begin
            // Leaving the rows wraps to the bit above them: both rows dark
            if (word_shr > lcpg_pkg::DBL_MASK || word_shr == '0) begin
                state_nxt.pattern_word = lcpg_pkg::WRAP_WORD;
            end else begin
                state_nxt.pattern_word = word_shr;
            end
            state_nxt.row_one = 8'(state_nxt.pattern_word) & lcpg_pkg::ROW_MASK;
            state_nxt.row_two = 8'(state_nxt.pattern_word >> lcpg_pkg::LEDS_PER_ROW)
                                & lcpg_pkg::ROW_MASK;
        end else if ((mode_bits & lcpg_pkg::MODE_KNIGHT) != '0) begin
            if (state_cur.row_one == '0) begin
                state_nxt.row_one = 8'd1;
                state_nxt.dir     = 1'b1;
            end else if (state_cur.dir) begin
                state_nxt.row_one = r1_shl;
                if (r1_shl >= lcpg_pkg::TOP_LED) begin
                    state_nxt.dir = 1'b0;
                end
            end else begin
                state_nxt.row_one = r1_shr;
                if (r1_shr <= 8'd1) begin
                    state_nxt.dir = 1'b1;
                end
            end
            state_nxt.row_two = state_nxt.row_one;
        end else if ((mode_bits & lcpg_pkg::MODE_MIRROR) != '0) begin
            if (state_cur.row_one == '0 || state_cur.row_two == '0 ||
                (state_cur.row_two & ~lcpg_pkg::ROW_MASK) != '0) begin
                state_nxt.row_one = 8'd1;
                state_nxt.row_two = lcpg_pkg::TOP_LED;
                state_nxt.dir     = 1'b1;
            end else if (state_cur.dir) begin
                state_nxt.row_one = r1_shl;
                state_nxt.row_two = r2_shr;
                if (r1_shl >= lcpg_pkg::TOP_LED) begin
                    state_nxt.dir = 1'b0;
                end
            end else begin
                state_nxt.row_one = r1_shr;
                state_nxt.row_two = r2_shl;
                if (r1_shr <= 8'd1) begin
                    state_nxt.dir = 1'b1;
                end
            end
        end else begin
            state_nxt = state_cur;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/led_chaser_pattern_generator.sv]
// Top level of the LED chaser pattern generator: stream ports, tick
// countdown, speed buttons and mode latch. Depends on lcpg_pkg, lcpg_pattern.
`default_nettype none

// Each input transaction is one sync tick carrying the button bytes and gives
// exactly one result transaction with both LED rows, the period, the mode and
// a step flag. A tick is taken into an input register, then worked through
// combinationally into the result register, so one tick per clock is sustained
// while results are taken, and a tick is accepted while the previous result
// still waits to be taken. The period registers are written by the user
// through the cfg port while no tick is in flight; the block does not enforce
// this. Index 0 is default_period, index 1 is max_period, others are ignored.
module led_chaser_pattern_generator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // [7:0] local_speed_buttons, [15:8] remote_speed_buttons,
    // [23:16] mode_buttons_a, [31:24] mode_buttons_b
    input  wire logic [31:0]                   s_tdata,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // [7:0] row_one_leds, [15:8] row_two_leds, [23:16] current_period,
    // [28:24] active_mode, [29] step_taken, [31:30] zero
    output      logic [31:0]                   m_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lcpg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_wdata
);

    logic                 in_valid_reg, in_valid_next;
    logic [31:0]          in_data_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [31:0]          out_data_reg;
    logic                 advance;

    logic [7:0]           default_period_reg;
    logic [7:0]           max_period_reg;

    lcpg_pkg::pat_state_t pat_reg, pat_next, pat_stepped;
    logic [4:0]           mode_reg, mode_next;
    logic [7:0]           cnt_reg, cnt_next;
    logic [7:0]           period_reg, period_next;
    logic [2:0]           latch_reg, latch_next;

    logic [2:0]           speed;
    logic [4:0]           modes;
    logic                 step;

    // Handshake: the input register frees when its tick moves to the result
    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign in_valid_next  = (s_tvalid && s_tready) ? 1'b1 :
                            (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 :
                            (m_tready ? 1'b0 : out_valid_reg);
    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = out_data_reg;

    // Decode the registered buttons
    assign speed = (in_data_reg[2:0] | in_data_reg[10:8]);
    assign modes = (in_data_reg[20:16] | in_data_reg[28:24]);

    assign mode_next = (modes != '0) ? modes : mode_reg;
    assign step      = (cnt_reg <= 8'd1);
    assign cnt_next  = step ? period_reg : (cnt_reg - 8'd1);

    lcpg_pattern u_pattern (
        .mode_bits (mode_next),
        .state_cur (pat_reg),
        .state_nxt (pat_stepped)
    );

    assign pat_next = step ? pat_stepped : pat_reg;

    // Edge-latched speed buttons: act once, then wait for release
    always_comb begin
        period_next = period_reg;
        latch_next  = latch_reg;
        if (latch_reg == '0) begin
            priority if ((speed & lcpg_pkg::SPEED_UP) != '0) begin
                if (period_reg < max_period_reg) begin
                    period_next = period_reg + 8'd1;
                end
                latch_next = speed;
            end else if ((speed & lcpg_pkg::SPEED_DOWN) != '0) begin
                if (period_reg > 8'd1) begin
                    period_next = period_reg - 8'd1;
                end
                latch_next = speed;
            end else if ((speed & lcpg_pkg::SPEED_RESET) != '0) begin
                period_next = default_period_reg;
                latch_next  = speed;
            end else begin
                latch_next = latch_reg;
            end
        end else if (speed == '0) begin
            latch_next = '0;
        end
    end

    // Handshake registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the incoming transaction
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    // Load the result
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {2'b00, step, mode_next, period_next,
                             pat_next.row_two, pat_next.row_one};
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_period_reg <= lcpg_pkg::DEFAULT_PERIOD_RST;
            max_period_reg     <= lcpg_pkg::MAX_PERIOD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lcpg_pkg::CFG_DEFAULT_PERIOD: default_period_reg <= cfg_wdata;
                lcpg_pkg::CFG_MAX_PERIOD:     max_period_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance the sequencer state once per tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg    <= '0;
            mode_reg   <= lcpg_pkg::MODE_RESET;
            cnt_reg    <= '0;
            period_reg <= lcpg_pkg::DEFAULT_PERIOD_RST;
            latch_reg  <= '0;
        end else if (advance) begin
            pat_reg    <= pat_next;
            mode_reg   <= mode_next;
            cnt_reg    <= cnt_next;
            period_reg <= period_next;
            latch_reg  <= latch_next;
        end
    end

    // A mode is always selected
    a_mode_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != '0)
        else $error("mode bits became zero");

    // A tick moving on always yields a result
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result missing after tick");

    // A step reloads the countdown from the period in use
    a_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && step) |=> (cnt_reg == $past(period_reg)))
        else $error("countdown not reloaded");

    // A held speed press leaves the period alone
    a_latch_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && latch_reg != '0) |=> (period_reg == $past(period_reg)))
        else $error("period changed while speed press latched");

    // A waiting tick is not lost
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending tick dropped");

endmodule

`default_nettype wire
